@@ rtl/ev_rtd_pkg.sv @@
// ----------------------------------------------------------------------------
// ev_rtd_pkg
// Shared types and constants of the precharge / ready-to-drive sequencer.
// ----------------------------------------------------------------------------
package ev_rtd_pkg;

	typedef enum logic [3:0] {
		ST_INIT     = 4'd0,
		ST_VCHECK   = 4'd1,
		ST_WAIT     = 4'd2,
		ST_PC1      = 4'd3,
		ST_PC2      = 4'd4,
		ST_PC3      = 4'd5,
		ST_NOTREADY = 4'd6,
		ST_BUZZER   = 4'd7,
		ST_CHARGING = 4'd8,
		ST_READY    = 4'd9
	} state_t;

	typedef enum logic [1:0] {
		DIR_NEUTRAL = 2'd0,
		DIR_DRIVE   = 2'd1,
		DIR_REVERSE = 2'd2
	} dir_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_MIN_PACK_VOLTAGE   = 3'd0;
	localparam logic [2:0] CFG_PRECHARGE_RATIO_Q8 = 3'd1;
	localparam logic [2:0] CFG_PRECHARGE_TIME_MS  = 3'd2;
	localparam logic [2:0] CFG_CONTACTOR_HOLD_MS  = 3'd3;
	localparam logic [2:0] CFG_BUZZER_TIME_MS     = 3'd4;
	localparam logic [2:0] CFG_MAX_START_THROTTLE = 3'd5;
	localparam logic [2:0] CFG_BUZZER_ENABLE      = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic [15:0] RST_MIN_PACK_VOLTAGE   = 16'd20000;
	localparam logic [8:0]  RST_PRECHARGE_RATIO_Q8 = 9'd230;
	localparam logic [15:0] RST_PRECHARGE_TIME_MS  = 16'd2000;
	localparam logic [15:0] RST_CONTACTOR_HOLD_MS  = 16'd500;
	localparam logic [15:0] RST_BUZZER_TIME_MS     = 16'd2000;
	localparam logic [15:0] RST_MAX_START_THROTTLE = 16'd500;
	localparam logic        RST_BUZZER_ENABLE      = 1'b1;

	typedef struct packed {
		logic [15:0] min_pack_voltage;
		logic [8:0]  precharge_ratio_q8;
		logic [15:0] precharge_time_ms;
		logic [15:0] contactor_hold_ms;
		logic [15:0] buzzer_time_ms;
		logic [15:0] max_start_throttle;
		logic        buzzer_enable;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic [15:0]        pack_voltage;
		logic signed [15:0] inv_a_voltage;
		logic signed [15:0] inv_b_voltage;
		logic [15:0]        throttle_pos;
		logic               throttle_ok;
		logic               is_charging;
		logic               precharge_pressed;
		logic               air1_closed;
		logic [1:0]         requested_mode;
	} tick_t;

	typedef struct packed {
		state_t vehicle_state;
		dir_t   drive_dir;
		logic   air2_on;
		logic   buzzer_on;
		logic   fans_on;
		logic   pumps_on;
	} result_t;

	// Sequencer context carried from one tick to the next
	typedef struct packed {
		state_t state;
		dir_t   last_dir;
		logic   lockout;
	} ctx_t;

	typedef struct packed {
		ctx_t ctx;
		logic start_load;
	} upd_t;

endpackage

@@ rtl/ev_rtd_tick_if.sv @@
// ----------------------------------------------------------------------------
// ev_rtd_tick_if
// Input channel: one evaluation tick per beat.
// ----------------------------------------------------------------------------
interface ev_rtd_tick_if;
	logic               valid;
	logic               ready;
	logic [31:0]        now_ms;
	logic [15:0]        pack_voltage;
	logic signed [15:0] inv_a_voltage;
	logic signed [15:0] inv_b_voltage;
	logic [15:0]        throttle_pos;
	logic               throttle_ok;
	logic               is_charging;
	logic               precharge_pressed;
	logic               air1_closed;
	logic [1:0]         requested_mode;

	modport source (
		output valid, now_ms, pack_voltage, inv_a_voltage, inv_b_voltage,
		output throttle_pos, throttle_ok, is_charging, precharge_pressed,
		output air1_closed, requested_mode,
		input  ready
	);

	modport sink (
		input  valid, now_ms, pack_voltage, inv_a_voltage, inv_b_voltage,
		input  throttle_pos, throttle_ok, is_charging, precharge_pressed,
		input  air1_closed, requested_mode,
		output ready
	);
endinterface

@@ rtl/ev_rtd_result_if.sv @@
// ----------------------------------------------------------------------------
// ev_rtd_result_if
// Output channel: state, direction and relay commands, one beat per tick.
// ----------------------------------------------------------------------------
interface ev_rtd_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] vehicle_state;
	logic [1:0] drive_dir;
	logic       air2_on;
	logic       buzzer_on;
	logic       fans_on;
	logic       pumps_on;

	modport source (
		output valid, vehicle_state, drive_dir, air2_on, buzzer_on, fans_on, pumps_on,
		input  ready
	);

	modport sink (
		input  valid, vehicle_state, drive_dir, air2_on, buzzer_on, fans_on, pumps_on,
		output ready
	);
endinterface

@@ rtl/ev_rtd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ev_rtd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ev_rtd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);

	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

@@ rtl/ev_rtd_step.sv @@
// ----------------------------------------------------------------------------
// ev_rtd_step
// Next-state and relay decode for one tick of the startup sequencer.
// ----------------------------------------------------------------------------
module ev_rtd_step #(
	parameter int TICK_BITS = 32
) (
	input  ev_rtd_pkg::ctx_t      ctx,
	input  logic [TICK_BITS-1:0]  stage_start,
	input  ev_rtd_pkg::tick_t     tk,
	input  ev_rtd_pkg::cfg_t      cfg,
	output ev_rtd_pkg::upd_t      upd,
	output ev_rtd_pkg::result_t   res
);
	import ev_rtd_pkg::*;

	logic [TICK_BITS-1:0] now_t;
	logic [TICK_BITS-1:0] delta;
	logic                 pc_elapsed;
	logic                 hold_elapsed;
	logic                 buzz_elapsed;
	logic [24:0]          need;
	logic signed [27:0]   a_sc;
	logic signed [27:0]   b_sc;
	logic                 rok;
	logic signed [20:0]   a_x10;
	logic signed [20:0]   b_x10;
	logic                 bus_low;
	logic                 lock_base;
	logic                 go_req;
	logic                 fwd_ok;
	logic                 rev_ok;
	logic                 run_ok;
	state_t               state_n;
	logic                 lock_n;
	logic                 load_n;
	dir_t                 dir;
	logic                 air2;
	logic                 buzz;
	logic                 fans;
	logic                 pumps;

	// Timers run modulo 2^TICK_BITS
	assign now_t        = TICK_BITS'(tk.now_ms);
	assign delta        = now_t - stage_start;
	assign pc_elapsed   = delta >= TICK_BITS'(cfg.precharge_time_ms);
	assign hold_elapsed = delta >= TICK_BITS'(cfg.contactor_hold_ms);
	assign buzz_elapsed = delta >= TICK_BITS'(cfg.buzzer_time_ms);

	// inv[0.1 V] >= pack[0.01 V] * ratio / 256  <=>  inv * 2560 >= pack * ratio
	assign need = 25'(tk.pack_voltage) * 25'(cfg.precharge_ratio_q8);
	assign a_sc = (28'(tk.inv_a_voltage) <<< 11) + (28'(tk.inv_a_voltage) <<< 9);
	assign b_sc = (28'(tk.inv_b_voltage) <<< 11) + (28'(tk.inv_b_voltage) <<< 9);
	assign rok  = (a_sc >= $signed({3'b000, need})) && (b_sc >= $signed({3'b000, need}));

	// Bus drop-out in ready: inv * 10 < min_pack_voltage
	assign a_x10   = (21'(tk.inv_a_voltage) <<< 3) + (21'(tk.inv_a_voltage) <<< 1);
	assign b_x10   = (21'(tk.inv_b_voltage) <<< 3) + (21'(tk.inv_b_voltage) <<< 1);
	assign bus_low = (a_x10 < $signed({5'b00000, cfg.min_pack_voltage}))
		|| (b_x10 < $signed({5'b00000, cfg.min_pack_voltage}));

	// A neutral request clears the lockout before the state is evaluated
	assign lock_base = ctx.lockout && (tk.requested_mode != DIR_NEUTRAL);
	assign go_req    = (tk.requested_mode == DIR_DRIVE) || (tk.requested_mode == DIR_REVERSE);
	assign fwd_ok    = (tk.requested_mode == DIR_DRIVE) && (ctx.last_dir != DIR_REVERSE);
	assign rev_ok    = (tk.requested_mode == DIR_REVERSE) && (ctx.last_dir != DIR_DRIVE);
	assign run_ok    = !bus_low && !tk.is_charging && tk.throttle_ok;

	// Next state, lockout and stage timer load
	always_comb begin
		state_n = ctx.state;
		lock_n  = lock_base;
		load_n  = 1'b0;
		case (ctx.state)
			ST_INIT: state_n = ST_VCHECK;
			ST_VCHECK: state_n = ST_WAIT;
			ST_WAIT: begin
				if (tk.precharge_pressed && tk.air1_closed
					&& (tk.pack_voltage >= cfg.min_pack_voltage)) begin
					state_n = ST_PC1;
					load_n  = 1'b1;
				end
			end
			ST_PC1: begin
				if (pc_elapsed)
					state_n = ST_PC2;
			end
			ST_PC2: begin
				if (rok) begin
					state_n = ST_PC3;
					load_n  = 1'b1;
				end else begin
					state_n = ST_WAIT;
				end
			end
			ST_PC3: begin
				if (hold_elapsed)
					state_n = rok ? ST_NOTREADY : ST_WAIT;
			end
			ST_NOTREADY: begin
				if (!rok) begin
					state_n = ST_WAIT;
				end else if (tk.is_charging) begin
					state_n = ST_CHARGING;
				end else if (!lock_base && go_req) begin
					lock_n = 1'b1;
					if (tk.throttle_ok && (tk.throttle_pos <= cfg.max_start_throttle)) begin
						state_n = ST_BUZZER;
						load_n  = 1'b1;
					end
				end
			end
			ST_BUZZER: begin
				if (!rok)
					state_n = ST_WAIT;
				else if (tk.is_charging)
					state_n = ST_CHARGING;
				else if (buzz_elapsed)
					state_n = ST_READY;
			end
			ST_CHARGING: begin
				if (!rok)
					state_n = ST_WAIT;
				else if (tk.is_charging)
					lock_n = 1'b1;
				else
					state_n = ST_NOTREADY;
			end
			ST_READY: begin
				if (bus_low) begin
					state_n = ST_WAIT;
				end else if (tk.is_charging) begin
					state_n = ST_CHARGING;
					lock_n  = 1'b1;
				end else if (!tk.throttle_ok) begin
					state_n = ST_WAIT;
				end else if (!(fwd_ok || rev_ok)) begin
					state_n = ST_NOTREADY;
				end
			end
			default: state_n = ST_WAIT;
		endcase
	end

	// Relay commands and direction
	always_comb begin
		dir   = DIR_NEUTRAL;
		air2  = 1'b0;
		buzz  = 1'b0;
		fans  = 1'b0;
		pumps = 1'b0;
		case (ctx.state)
			ST_PC2: air2 = rok;
			ST_PC3: air2 = !hold_elapsed || rok;
			ST_NOTREADY: air2 = rok;
			ST_BUZZER: begin
				air2 = rok;
				buzz = rok && !tk.is_charging && !buzz_elapsed;
			end
			ST_CHARGING: begin
				air2 = rok;
				fans = rok;
			end
			ST_READY: begin
				air2  = !bus_low;
				pumps = run_ok && (fwd_ok || rev_ok);
				if (run_ok && fwd_ok)
					dir = DIR_DRIVE;
				else if (run_ok && rev_ok)
					dir = DIR_REVERSE;
			end
			default: air2 = 1'b0;
		endcase
	end

	assign upd.ctx.state    = state_n;
	assign upd.ctx.last_dir = dir;
	assign upd.ctx.lockout  = lock_n;
	assign upd.start_load   = load_n;

	assign res.vehicle_state = state_n;
	assign res.drive_dir     = dir;
	assign res.air2_on       = air2;
	assign res.buzzer_on     = buzz && cfg.buzzer_enable;
	assign res.fans_on       = fans;
	assign res.pumps_on      = pumps;

endmodule

@@ rtl/ev_precharge_ready_to_drive_fsm.sv @@
// ----------------------------------------------------------------------------
// ev_precharge_ready_to_drive_fsm
// Startup sequencer of an electric vehicle: precharge, buzzer, charging and
// ready-to-drive, with relay commands out for every evaluation tick.
//
// Channels: tick (sink) takes one evaluation tick per beat; result (source)
// returns one beat per tick with the new state, drive direction and the four
// relay commands; cfg (sink) writes one register per beat and is always ready.
// Path: an accepted tick is registered in the input stage, decoded against
// the sequencer context and shown on result from the result register.
// Throughput: one tick per cycle while result is taken; the input stage and
// the result register are the two stages, and the sequencer context updates
// as a tick moves between them, so the next tick always sees the state left
// by the one before. Stall: when result is not taken, the result register
// holds and the input stage fills; tick.ready drops only while both are full.
// Reset: state goes to init, direction neutral, stage timer 0, drive locked
// out, registers to their defaults; both stages empty.
// ----------------------------------------------------------------------------
module ev_precharge_ready_to_drive_fsm #(
	parameter int TICK_BITS = 32
) (
	input logic               clk,
	input logic               arst_n,
	ev_rtd_tick_if.sink       tick,
	ev_rtd_result_if.source   result,
	ev_rtd_cfg_if.sink        cfg
);
	import ev_rtd_pkg::*;

	cfg_t                 cfg_q;
	ctx_t                 ctx_q;
	logic [TICK_BITS-1:0] start_q;
	tick_t                tick_s1;
	logic                 valid_s1;
	result_t              res_q;
	logic                 res_valid_q;
	tick_t                tick_in;
	upd_t                 upd;
	result_t              res_n;
	logic                 adv;
	logic                 tick_acc;

	assign tick_in.now_ms            = tick.now_ms;
	assign tick_in.pack_voltage      = tick.pack_voltage;
	assign tick_in.inv_a_voltage     = tick.inv_a_voltage;
	assign tick_in.inv_b_voltage     = tick.inv_b_voltage;
	assign tick_in.throttle_pos      = tick.throttle_pos;
	assign tick_in.throttle_ok       = tick.throttle_ok;
	assign tick_in.is_charging       = tick.is_charging;
	assign tick_in.precharge_pressed = tick.precharge_pressed;
	assign tick_in.air1_closed       = tick.air1_closed;
	assign tick_in.requested_mode    = tick.requested_mode;

	// Move the held tick on when the result register is free or being drained
	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || adv;
	assign tick_acc   = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pack_voltage   <= RST_MIN_PACK_VOLTAGE;
			cfg_q.precharge_ratio_q8 <= RST_PRECHARGE_RATIO_Q8;
			cfg_q.precharge_time_ms  <= RST_PRECHARGE_TIME_MS;
			cfg_q.contactor_hold_ms  <= RST_CONTACTOR_HOLD_MS;
			cfg_q.buzzer_time_ms     <= RST_BUZZER_TIME_MS;
			cfg_q.max_start_throttle <= RST_MAX_START_THROTTLE;
			cfg_q.buzzer_enable      <= RST_BUZZER_ENABLE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MIN_PACK_VOLTAGE:   cfg_q.min_pack_voltage   <= cfg.data;
				CFG_PRECHARGE_RATIO_Q8: cfg_q.precharge_ratio_q8 <= cfg.data[8:0];
				CFG_PRECHARGE_TIME_MS:  cfg_q.precharge_time_ms  <= cfg.data;
				CFG_CONTACTOR_HOLD_MS:  cfg_q.contactor_hold_ms  <= cfg.data;
				CFG_BUZZER_TIME_MS:     cfg_q.buzzer_time_ms     <= cfg.data;
				CFG_MAX_START_THROTTLE: cfg_q.max_start_throttle <= cfg.data;
				CFG_BUZZER_ENABLE:      cfg_q.buzzer_enable      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (tick_acc)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (tick_acc)
			tick_s1 <= tick_in;
	end

	ev_rtd_step #(
		.TICK_BITS (TICK_BITS)
	) u_step (
		.ctx         (ctx_q),
		.stage_start (start_q),
		.tk          (tick_s1),
		.cfg         (cfg_q),
		.upd         (upd),
		.res         (res_n)
	);

	// Sequencer context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state    <= ST_INIT;
			ctx_q.last_dir <= DIR_NEUTRAL;
			ctx_q.lockout  <= 1'b1;
			start_q        <= '0;
		end else if (adv) begin
			ctx_q <= upd.ctx;
			if (upd.start_load)
				start_q <= TICK_BITS'(tick_s1.now_ms);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_n;
	end

	assign result.valid         = res_valid_q;
	assign result.vehicle_state = res_q.vehicle_state;
	assign result.drive_dir     = res_q.drive_dir;
	assign result.air2_on       = res_q.air2_on;
	assign result.buzzer_on     = res_q.buzzer_on;
	assign result.fans_on       = res_q.fans_on;
	assign result.pumps_on      = res_q.pumps_on;

`ifndef ASSERT_OFF
	// A decoded tick always lands in the result register
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (result.valid && (ctx_q.state == res_q.vehicle_state)))
		else $error("decoded beat not presented on result");

	// Second contactor stays open before the last precharge stage
	a_air2_states: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.air2_on) |->
			(result.vehicle_state != ST_INIT && result.vehicle_state != ST_VCHECK
			&& result.vehicle_state != ST_PC1 && result.vehicle_state != ST_PC2))
		else $error("air2 commanded before the last precharge stage");

	// Pumps run only while driving with a direction
	a_pumps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.pumps_on) |->
			(result.vehicle_state == ST_READY && result.drive_dir != DIR_NEUTRAL
			&& result.air2_on))
		else $error("pumps on outside ready-to-drive");

	// Buzzer only sounds in its own state
	a_buzz_state: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.buzzer_on) |->
			(result.vehicle_state == ST_BUZZER && cfg_q.buzzer_enable))
		else $error("buzzer on outside buzzer state");
`endif

endmodule
